// ----- rtl/gate_netlist_truth_table_defines.svh -----
`ifndef GATE_NETLIST_TRUTH_TABLE_DEFINES_SVH
`define GATE_NETLIST_TRUTH_TABLE_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define GNTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define GNTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gntt_pkg.sv -----
package gntt_pkg;

    localparam int IDX_W   = 6;
    localparam int CNT_W   = 5;
    localparam int ROW_W   = 16;
    localparam int IN_CAP  = 16;
    localparam int OUT_CAP = 16;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_ROW   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [2:0] OP_NOT  = 3'd0;
    localparam logic [2:0] OP_AND  = 3'd1;
    localparam logic [2:0] OP_OR   = 3'd2;
    localparam logic [2:0] OP_NAND = 3'd3;
    localparam logic [2:0] OP_NOR  = 3'd4;
    localparam logic [2:0] OP_XOR  = 3'd5;

    localparam logic [0:0] REG_INPUT_COUNT  = 1'b0;
    localparam logic [0:0] REG_OUTPUT_COUNT = 1'b1;

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] src_a;
        logic [IDX_W-1:0] src_b;
        logic [IDX_W-1:0] dst;
    } gate_t;

    typedef struct packed {
        logic [CNT_W-1:0] input_count;
        logic [CNT_W-1:0] output_count;
    } cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0] input_bits;
        logic [ROW_W-1:0] output_bits;
        logic             last_row;
        logic             list_full;
    } result_t;

endpackage

// ----- rtl/gntt_ram.sv -----
module gntt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/gntt_apb_regs.sv -----
module gntt_apb_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output gntt_pkg::cfg_t       cfg
);

    logic [gntt_pkg::CNT_W-1:0] input_count_reg;
    logic [gntt_pkg::CNT_W-1:0] output_count_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg  <= gntt_pkg::CNT_W'(1);
            output_count_reg <= gntt_pkg::CNT_W'(1);
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                gntt_pkg::REG_INPUT_COUNT:  input_count_reg  <= pwdata[gntt_pkg::CNT_W-1:0];
                gntt_pkg::REG_OUTPUT_COUNT: output_count_reg <= pwdata[gntt_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            gntt_pkg::REG_INPUT_COUNT:  prdata = 32'(input_count_reg);
            gntt_pkg::REG_OUTPUT_COUNT: prdata = 32'(output_count_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.input_count  = input_count_reg;
    assign cfg.output_count = output_count_reg;

endmodule

// ----- rtl/gntt_core.sv -----
`include "gate_netlist_truth_table_defines.svh"

module gntt_core #(
    parameter int MAX_VARS  = 64,
    parameter int MAX_GATES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gntt_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_mode,
    input  gntt_pkg::gate_t   in_gate,
    input  logic              out_free,
    output logic              res_valid,
    output gntt_pkg::result_t res
);

    localparam int GAW   = $clog2(MAX_GATES);
    localparam int GTW   = GAW + 1;
    localparam int VAW   = $clog2(MAX_VARS);
    localparam int GATEW = $bits(gntt_pkg::gate_t);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_GATES = 7'b0000100,
        ST_DRAIN = 7'b0001000,
        ST_OUTS  = 7'b0010000,
        ST_OWAIT = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [GTW-1:0]                  gate_total_reg, gate_total_next;
    logic [gntt_pkg::ROW_W-1:0]      row_index_reg, row_index_next;
    logic [gntt_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [gntt_pkg::ROW_W-1:0]      obits_reg, obits_next;
    logic [3:0]                      step_reg, step_next;
    logic [GAW-1:0]                  gi_reg, gi_next;
    logic                            p1_valid_reg, p1_valid_next;
    logic                            p2_valid_reg;
    gntt_pkg::gate_t                 p2_gate_reg;
    logic                            va_reg, vb_reg;
    logic                            o_pend_reg, o_pend_next;
    logic                            o_inr_reg, o_inr_next;
    logic                            fwd_en_reg;
    logic [gntt_pkg::IDX_W-1:0]      fwd_idx_reg;
    logic                            fwd_val_reg;
    logic [MAX_VARS-1:0]             var_valid_reg;

    logic [gntt_pkg::CNT_W-1:0]      n_eff, m_eff;
    logic [gntt_pkg::ROW_W-1:0]      mask;
    logic [GATEW-1:0]                gate_rdata;
    gntt_pkg::gate_t                 gate_q;
    logic                            gate_we;
    logic [gntt_pkg::IDX_W-1:0]      out_idx;
    logic                            out_inr;
    logic                            load_inr;
    logic                            load_bit;
    logic [VAW-1:0]                  var_raddr_a, var_raddr_b;
    logic                            var_qa, var_qb;
    logic                            var_we;
    logic [VAW-1:0]                  var_waddr;
    logic                            var_wdata;
    logic                            a_inr, b_inr, d_inr;
    logic                            xa, xb;
    logic                            g_val, g_op_ok;
    logic                            gw_en;

    always_comb
    begin
        if (cfg.input_count == '0)
            n_eff = gntt_pkg::CNT_W'(1);
        else if (cfg.input_count > gntt_pkg::CNT_W'(gntt_pkg::IN_CAP))
            n_eff = gntt_pkg::CNT_W'(gntt_pkg::IN_CAP);
        else
            n_eff = cfg.input_count;

        if (cfg.output_count == '0)
            m_eff = gntt_pkg::CNT_W'(1);
        else if (cfg.output_count > gntt_pkg::CNT_W'(gntt_pkg::OUT_CAP))
            m_eff = gntt_pkg::CNT_W'(gntt_pkg::OUT_CAP);
        else
            m_eff = cfg.output_count;
    end

    assign mask = gntt_pkg::ROW_W'((17'd1 << n_eff) - 17'd1);

    assign gate_we = (state_reg == ST_IDLE) && in_valid && (in_mode == gntt_pkg::MODE_LOAD)
                     && (32'(gate_total_reg) < MAX_GATES);

    gntt_ram #(
        .WIDTH (GATEW),
        .DEPTH (MAX_GATES)
    ) u_gate_ram (
        .clk   (clk),
        .we    (gate_we),
        .waddr (gate_total_reg[GAW-1:0]),
        .wdata (in_gate),
        .raddr (gi_reg),
        .rdata (gate_rdata)
    );

    assign gate_q = gntt_pkg::gate_t'(gate_rdata);

    // The variable store is kept in two identical banks so that both gate
    // operands can be read in the same cycle.
    gntt_ram #(
        .WIDTH (1),
        .DEPTH (MAX_VARS)
    ) u_var_ram_a (
        .clk   (clk),
        .we    (var_we),
        .waddr (var_waddr),
        .wdata (var_wdata),
        .raddr (var_raddr_a),
        .rdata (var_qa)
    );

    gntt_ram #(
        .WIDTH (1),
        .DEPTH (MAX_VARS)
    ) u_var_ram_b (
        .clk   (clk),
        .we    (var_we),
        .waddr (var_waddr),
        .wdata (var_wdata),
        .raddr (var_raddr_b),
        .rdata (var_qb)
    );

    assign out_idx  = gntt_pkg::IDX_W'(n_eff) + gntt_pkg::IDX_W'(step_reg);
    assign out_inr  = 32'(out_idx) < MAX_VARS;
    assign load_inr = 32'(step_reg) < MAX_VARS;
    assign load_bit = row_reg[4'(n_eff - 5'd1 - {1'b0, step_reg})];

    assign var_raddr_a = (state_reg == ST_OUTS) ? VAW'(out_idx) : VAW'(gate_q.src_a);
    assign var_raddr_b = VAW'(gate_q.src_b);

    // Gate evaluation stage. The write of the previous gate lands at the same
    // edge as this gate's operand read, so it is forwarded.
    assign a_inr = 32'(p2_gate_reg.src_a) < MAX_VARS;
    assign b_inr = 32'(p2_gate_reg.src_b) < MAX_VARS;
    assign d_inr = 32'(p2_gate_reg.dst) < MAX_VARS;

    assign xa = (fwd_en_reg && (fwd_idx_reg == p2_gate_reg.src_a)) ? fwd_val_reg
                : (a_inr && va_reg && var_qa);
    assign xb = (fwd_en_reg && (fwd_idx_reg == p2_gate_reg.src_b)) ? fwd_val_reg
                : (b_inr && vb_reg && var_qb);

    always_comb
    begin
        g_op_ok = 1'b1;
        g_val   = 1'b0;
        unique case (p2_gate_reg.op)
            gntt_pkg::OP_NOT:  g_val = !xa;
            gntt_pkg::OP_AND:  g_val = xa & xb;
            gntt_pkg::OP_OR:   g_val = xa | xb;
            gntt_pkg::OP_NAND: g_val = !(xa & xb);
            gntt_pkg::OP_NOR:  g_val = !(xa | xb);
            gntt_pkg::OP_XOR:  g_val = xa ^ xb;
            default:           g_op_ok = 1'b0;
        endcase
    end

    assign gw_en = p2_valid_reg && g_op_ok && d_inr;

    always_comb
    begin
        var_we    = 1'b0;
        var_waddr = VAW'(p2_gate_reg.dst);
        var_wdata = g_val;
        priority if (p2_valid_reg)
        begin
            var_we = gw_en;
        end
        else if (state_reg == ST_LOAD)
        begin
            var_we    = load_inr;
            var_waddr = VAW'(step_reg);
            var_wdata = load_bit;
        end
        else if (state_reg == ST_OUTS)
        begin
            var_we    = out_inr;
            var_waddr = VAW'(out_idx);
            var_wdata = 1'b0;
        end
        else
        begin
            var_we = 1'b0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        gate_total_next = gate_total_reg;
        row_index_next  = row_index_reg;
        row_next        = row_reg;
        step_next       = step_reg;
        gi_next         = gi_reg;
        p1_valid_next   = 1'b0;
        o_pend_next     = 1'b0;
        o_inr_next      = out_inr;
        res_valid       = 1'b0;
        obits_next      = obits_reg;

        if (o_pend_reg)
        begin
            obits_next = {obits_reg[gntt_pkg::ROW_W-2:0], o_inr_reg && va_reg && var_qa};
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_mode)
                        gntt_pkg::MODE_LOAD:
                        begin
                            if (gate_we)
                            begin
                                gate_total_next = gate_total_reg + GTW'(1);
                            end
                        end
                        gntt_pkg::MODE_CLEAR:
                        begin
                            gate_total_next = '0;
                            row_index_next  = '0;
                        end
                        gntt_pkg::MODE_ROW:
                        begin
                            row_next   = row_index_reg & mask;
                            obits_next = '0;
                            step_next  = '0;
                            state_next = ST_LOAD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(n_eff - 5'd1))
                begin
                    step_next = '0;
                    gi_next   = '0;
                    if (gate_total_reg == '0)
                        state_next = ST_OUTS;
                    else
                        state_next = ST_GATES;
                end
            end
            ST_GATES:
            begin
                p1_valid_next = 1'b1;
                gi_next       = gi_reg + GAW'(1);
                if (GTW'(gi_reg) == (gate_total_reg - GTW'(1)))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = ST_OUTS;
                end
            end
            ST_OUTS:
            begin
                o_pend_next = 1'b1;
                step_next   = step_reg + 4'd1;
                if (step_reg == 4'(m_eff - 5'd1))
                begin
                    state_next = ST_OWAIT;
                end
            end
            ST_OWAIT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_valid      = 1'b1;
                    row_index_next = (row_reg + gntt_pkg::ROW_W'(1)) & mask;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            gate_total_reg <= '0;
            row_index_reg  <= '0;
            step_reg       <= '0;
            gi_reg         <= '0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            o_pend_reg     <= 1'b0;
            fwd_en_reg     <= 1'b0;
            var_valid_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            gate_total_reg <= gate_total_next;
            row_index_reg  <= row_index_next;
            step_reg       <= step_next;
            gi_reg         <= gi_next;
            p1_valid_reg   <= p1_valid_next;
            p2_valid_reg   <= p1_valid_reg;
            o_pend_reg     <= o_pend_next;
            fwd_en_reg     <= gw_en;
            if (var_we)
            begin
                var_valid_reg[var_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        obits_reg   <= obits_next;
        p2_gate_reg <= gate_q;
        va_reg      <= var_valid_reg[var_raddr_a];
        vb_reg      <= var_valid_reg[var_raddr_b];
        o_inr_reg   <= o_inr_next;
        fwd_idx_reg <= p2_gate_reg.dst;
        fwd_val_reg <= g_val;
    end

    assign in_ready        = (state_reg == ST_IDLE);
    assign res.input_bits  = row_reg;
    assign res.output_bits = obits_reg;
    assign res.last_row    = (row_reg == mask);
    assign res.list_full   = 32'(gate_total_reg) >= MAX_GATES;

    `GNTT_ASSERT_NOW(a_emit_free, res_valid, out_free,
                     "result issued while output register is full")
    `GNTT_ASSERT_NOW(a_total_cap, 1'b1, 32'(gate_total_reg) <= MAX_GATES,
                     "gate count exceeds capacity")
    `GNTT_ASSERT_NOW(a_eval_phase, p2_valid_reg,
                     (state_reg == ST_GATES) || (state_reg == ST_DRAIN),
                     "gate evaluated outside the gate walk")
    `GNTT_ASSERT_NEXT(a_emit_idle, res_valid,
                      (state_reg == ST_IDLE) && !p1_valid_reg && !p2_valid_reg,
                      "sequencer busy after emitting a row")

endmodule

// ----- rtl/gate_netlist_truth_table.sv -----
// Truth-table generator over a loaded netlist of one- and two-input gates.
// Input stream (s_*): one transaction per command. tuser selects the command:
// load a gate, evaluate the next row, or clear the gate list and row counter.
// Load and clear produce no output transaction.
// A row command loads the input variables from the row counter (one per cycle),
// walks the gate list through the gate memory one gate per cycle, then reads
// and clears the output variables one per cycle. With an empty gate list the
// gate walk is skipped. After the row is emitted the block returns to idle and
// accepts the next command in the following cycle.
// Output stream (m_*): one transaction per row, tlast marks the final row of
// the table. The result sits in an output register, so the next command is
// accepted while it waits. If the receiver stalls, the following row stops
// just before its emit and resumes once the register is taken.
// Configuration: APB registers input_count at 0x0 and output_count at 0x4, to
// be written by the user only while idle; the block itself does not enforce it.
// Reset empties the gate list, zeroes the row counter and all variables, and
// sets both counts to one. No clearing pass is needed after reset.
module gate_netlist_truth_table #(
    parameter int MAX_VARS  = 64,
    parameter int MAX_GATES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // gate_op[2:0], src_a[8:3], src_b[14:9], dst[20:15], zero
    input  logic [1:0]  s_tuser,  // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // input_bits[15:0], output_bits[31:16], list_full[32], zero
    output logic        m_tlast
);

    gntt_pkg::cfg_t    cfg;
    gntt_pkg::gate_t   in_gate;
    gntt_pkg::result_t res;
    logic              res_valid;
    logic              out_free;
    logic              m_tvalid_reg;
    gntt_pkg::result_t out_reg;

    gntt_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_gate.op    = s_tdata[2:0];
    assign in_gate.src_a = s_tdata[8:3];
    assign in_gate.src_b = s_tdata[14:9];
    assign in_gate.dst   = s_tdata[20:15];

    gntt_core #(
        .MAX_VARS  (MAX_VARS),
        .MAX_GATES (MAX_GATES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_gate   (in_gate),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_reg.list_full, out_reg.output_bits, out_reg.input_bits};
    assign m_tlast  = out_reg.last_row;

endmodule

// ----- tb/tb_top.sv -----
package tb_truth_table_pkg;

    localparam int         GATE_CAPACITY = 256;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [2:0] OP_SPARE6     = 3'd6;
    localparam logic [2:0] OP_SPARE7     = 3'd7;

    class row_result_checker;
        gntt_pkg::gate_t   netlist[$];
        bit [63:0]         var_bits;
        logic [15:0]       row_counter;
        logic [4:0]        input_count_reg;
        logic [4:0]        output_count_reg;
        gntt_pkg::result_t pending_rows[$];
        int                error_count;
        int                rows_checked;
        int                final_rows_seen;
        int                full_list_rows;

        function new();
            var_bits         = '0;
            row_counter      = '0;
            input_count_reg  = 5'd1;
            output_count_reg = 5'd1;
            error_count      = 0;
            rows_checked     = 0;
            final_rows_seen  = 0;
            full_list_rows   = 0;
        endfunction

        function void report(string what);
            error_count++;
            if (error_count <= 40)
            begin
                $display("MISMATCH at %0t: %s", $realtime, what);
            end
        endfunction

        function void write_register(logic [0:0] index, logic [4:0] value);
            if (index == gntt_pkg::REG_INPUT_COUNT)
            begin
                input_count_reg = value;
            end
            else
            begin
                output_count_reg = value;
            end
        endfunction

        function int active_inputs();
            if (input_count_reg < 1)
            begin
                return 1;
            end
            return (input_count_reg > gntt_pkg::IN_CAP) ? gntt_pkg::IN_CAP
                                                        : int'(input_count_reg);
        endfunction

        function int active_outputs();
            if (output_count_reg < 1)
            begin
                return 1;
            end
            return (output_count_reg > gntt_pkg::OUT_CAP) ? gntt_pkg::OUT_CAP
                                                          : int'(output_count_reg);
        endfunction

        function void apply_gate(gntt_pkg::gate_t g);
            bit x;
            bit y;
            bit v;
            bit writes;
            x      = var_bits[g.src_a];
            y      = var_bits[g.src_b];
            writes = 1'b1;
            v      = 1'b0;
            case (g.op)
                gntt_pkg::OP_NOT:  v = ~x;
                gntt_pkg::OP_AND:  v = x & y;
                gntt_pkg::OP_OR:   v = x | y;
                gntt_pkg::OP_NAND: v = ~(x & y);
                gntt_pkg::OP_NOR:  v = ~(x | y);
                gntt_pkg::OP_XOR:  v = x ^ y;
                default: writes = 1'b0;
            endcase
            if (writes)
            begin
                var_bits[g.dst] = v;
            end
        endfunction

        function gntt_pkg::result_t evaluate_row();
            int                n;
            int                m;
            logic [15:0]       mask;
            logic [15:0]       row;
            gntt_pkg::result_t r;
            n    = active_inputs();
            m    = active_outputs();
            mask = 16'((32'd1 << n) - 1);
            row  = row_counter & mask;
            for (int i = 0; i < n; i++)
            begin
                var_bits[i] = row[n - 1 - i];
            end
            foreach (netlist[i])
            begin
                apply_gate(netlist[i]);
            end
            r.input_bits  = row;
            r.output_bits = '0;
            for (int i = 0; i < m; i++)
            begin
                r.output_bits = {r.output_bits[14:0], var_bits[n + i]};
            end
            r.last_row    = (row == mask);
            r.list_full   = (netlist.size() >= GATE_CAPACITY);
            row_counter   = (row + 16'd1) & mask;
            for (int i = 0; i < m; i++)
            begin
                var_bits[n + i] = 1'b0;
            end
            return r;
        endfunction

        function void note_command(logic [1:0] mode, gntt_pkg::gate_t g);
            case (mode)
                gntt_pkg::MODE_LOAD:
                begin
                    if (netlist.size() < GATE_CAPACITY)
                    begin
                        netlist.push_back(g);
                    end
                end
                gntt_pkg::MODE_CLEAR:
                begin
                    netlist.delete();
                    row_counter = '0;
                end
                gntt_pkg::MODE_ROW: pending_rows.push_back(evaluate_row());
                default: ;
            endcase
        endfunction

        function void check_row(gntt_pkg::result_t got);
            gntt_pkg::result_t want;
            if (pending_rows.size() == 0)
            begin
                report($sformatf("row result %h arrived with nothing pending", got));
                return;
            end
            want = pending_rows.pop_front();
            rows_checked++;
            if (want.last_row)
            begin
                final_rows_seen++;
            end
            if (want.list_full)
            begin
                full_list_rows++;
            end
            if (got.input_bits !== want.input_bits)
            begin
                report($sformatf("input_bits %h, expected %h", got.input_bits, want.input_bits));
            end
            if (got.output_bits !== want.output_bits)
            begin
                report($sformatf("output_bits %h, expected %h (inputs %h)",
                                 got.output_bits, want.output_bits, want.input_bits));
            end
            if (got.last_row !== want.last_row)
            begin
                report($sformatf("last_row %b, expected %b (inputs %h)",
                                 got.last_row, want.last_row, want.input_bits));
            end
            if (got.list_full !== want.list_full)
            begin
                report($sformatf("list_full %b, expected %b", got.list_full, want.list_full));
            end
        endfunction
    endclass
endpackage

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 5000000;
    localparam int SETTLE_CYCLES = 400;
    localparam int PHASE_ITEMS   = 120;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;  // gate_op[2:0], src_a[8:3], src_b[14:9], dst[20:15], zero
    logic [1:0]  s_tuser;  // mode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;  // input_bits[15:0], output_bits[31:16], list_full[32], zero
    logic        m_tlast;

    tb_truth_table_pkg::row_result_checker tt_checker = new();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int cycle_count;
    int items_sent;
    int loads_sent;
    int rows_sent;
    int clears_sent;
    int unused_sent;

    gate_netlist_truth_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d rows pending.",
                 cycle_count, tt_checker.pending_rows.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        gntt_pkg::result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.input_bits  = m_tdata[15:0];
            got.output_bits = m_tdata[31:16];
            got.last_row    = m_tlast;
            got.list_full   = m_tdata[32];
            tt_checker.check_row(got);
        end
    end

    function automatic gntt_pkg::gate_t make_gate(logic [2:0] op, logic [5:0] a,
                                                  logic [5:0] b, logic [5:0] d);
        gntt_pkg::gate_t g;
        g.op    = op;
        g.src_a = a;
        g.src_b = b;
        g.dst   = d;
        return g;
    endfunction

    function automatic logic [5:0] pick_index();
        int span;
        span = tt_checker.active_inputs() + tt_checker.active_outputs() + 6;
        if (span > 63 || $urandom_range(0, 7) == 0)
        begin
            span = 63;
        end
        return 6'($urandom_range(0, span));
    endfunction

    function automatic gntt_pkg::gate_t random_gate(bit wellformed);
        logic [2:0] op;
        if (!wellformed)
        begin
            return make_gate(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        end
        op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                         : 3'($urandom_range(0, 5));
        return make_gate(op, pick_index(), pick_index(), pick_index());
    endfunction

    task automatic send_command(logic [1:0] mode, gntt_pkg::gate_t g);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, g.dst, g.src_b, g.src_a, g.op};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        tt_checker.note_command(mode, g);
        items_sent++;
        case (mode)
            gntt_pkg::MODE_LOAD:  loads_sent++;
            gntt_pkg::MODE_ROW:   rows_sent++;
            gntt_pkg::MODE_CLEAR: clears_sent++;
            default:              unused_sent++;
        endcase
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (tt_checker.pending_rows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [0:0] index, logic [4:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {27'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (pready !== 1'b1)
        begin
            tt_checker.report($sformatf("pready low during write of register %0d", index));
        end
        tt_checker.write_register(index, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {27'd0, value})
        begin
            tt_checker.report($sformatf("register %0d reads %h, expected %h",
                                        index, prdata, value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic fill_netlist();
        send_command(gntt_pkg::MODE_CLEAR, random_gate(1'b0));
        repeat (tb_truth_table_pkg::GATE_CAPACITY + 4)
            send_command(gntt_pkg::MODE_LOAD, random_gate(1'b1));
        repeat (4) send_command(gntt_pkg::MODE_ROW, random_gate(1'b0));
    endtask

    task automatic run_sequence();
        int choice;
        int limit;
        choice = $urandom_range(0, 99);
        if (choice < 80)
        begin
            send_command(gntt_pkg::MODE_CLEAR, random_gate(1'b0));
            repeat ($urandom_range(1, 24)) send_command(gntt_pkg::MODE_LOAD, random_gate(1'b1));
            limit = (tt_checker.active_inputs() > 3) ? 12
                                                    : (1 << tt_checker.active_inputs()) + 2;
            repeat ($urandom_range(1, limit))
                send_command(gntt_pkg::MODE_ROW, random_gate(1'b0));
        end
        else if (choice < 90)
        begin
            repeat ($urandom_range(1, 4)) send_command(gntt_pkg::MODE_LOAD, random_gate(1'b1));
            repeat ($urandom_range(1, 6)) send_command(gntt_pkg::MODE_ROW, random_gate(1'b0));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                send_command(2'($urandom_range(0, 3)), random_gate(1'b0));
            end
        end
    endtask

    task automatic directed_commands();
        send_command(gntt_pkg::MODE_ROW, make_gate(gntt_pkg::OP_NOT, 6'd0, 6'd0, 6'd0));
        send_command(gntt_pkg::MODE_ROW, make_gate(gntt_pkg::OP_NOT, 6'd0, 6'd0, 6'd0));
        send_command(gntt_pkg::MODE_LOAD, make_gate(gntt_pkg::OP_NOT, 6'd0, 6'd0, 6'd1));
        send_command(gntt_pkg::MODE_ROW, make_gate(gntt_pkg::OP_NOT, 6'd0, 6'd0, 6'd0));
        send_command(gntt_pkg::MODE_ROW, make_gate(gntt_pkg::OP_NOT, 6'd0, 6'd0, 6'd0));
        send_command(gntt_pkg::MODE_LOAD, make_gate(gntt_pkg::OP_AND, 6'd0, 6'd63, 6'd2));
        send_command(gntt_pkg::MODE_LOAD, make_gate(gntt_pkg::OP_OR, 6'd63, 6'd0, 6'd3));
        send_command(gntt_pkg::MODE_LOAD, make_gate(gntt_pkg::OP_NAND, 6'd2, 6'd3, 6'd63));
        send_command(gntt_pkg::MODE_LOAD, make_gate(gntt_pkg::OP_NOR, 6'd63, 6'd63, 6'd1));
        send_command(gntt_pkg::MODE_LOAD, make_gate(gntt_pkg::OP_XOR, 6'd0, 6'd1, 6'd1));
        send_command(gntt_pkg::MODE_LOAD,
                     make_gate(tb_truth_table_pkg::OP_SPARE6, 6'd63, 6'd63, 6'd1));
        send_command(gntt_pkg::MODE_LOAD,
                     make_gate(tb_truth_table_pkg::OP_SPARE7, 6'd0, 6'd0, 6'd1));
        send_command(tb_truth_table_pkg::MODE_UNUSED,
                     make_gate(tb_truth_table_pkg::OP_SPARE7, 6'd63, 6'd63, 6'd63));
        send_command(gntt_pkg::MODE_ROW, make_gate(gntt_pkg::OP_NOT, 6'd0, 6'd0, 6'd0));
        send_command(gntt_pkg::MODE_ROW, make_gate(gntt_pkg::OP_NOT, 6'd0, 6'd0, 6'd0));
        send_command(gntt_pkg::MODE_LOAD, make_gate(gntt_pkg::OP_NOT, 6'd1, 6'd0, 6'd0));
        send_command(gntt_pkg::MODE_LOAD, make_gate(gntt_pkg::OP_XOR, 6'd0, 6'd63, 6'd1));
        send_command(gntt_pkg::MODE_ROW, make_gate(gntt_pkg::OP_NOT, 6'd0, 6'd0, 6'd0));
        send_command(gntt_pkg::MODE_ROW, make_gate(gntt_pkg::OP_NOT, 6'd0, 6'd0, 6'd0));
        send_command(gntt_pkg::MODE_CLEAR,
                     make_gate(tb_truth_table_pkg::OP_SPARE7, 6'd63, 6'd63, 6'd63));
        send_command(gntt_pkg::MODE_ROW, make_gate(gntt_pkg::OP_NOT, 6'd0, 6'd0, 6'd0));
        send_command(gntt_pkg::MODE_LOAD, make_gate(gntt_pkg::OP_NOR, 6'd63, 6'd5, 6'd1));
        send_command(gntt_pkg::MODE_ROW, make_gate(gntt_pkg::OP_NOT, 6'd0, 6'd0, 6'd0));
    endtask

    initial
    begin
        int phase_inputs[8];
        int phase_outputs[8];
        int target;
        phase_inputs  = '{3, 16, 0, 31, 2, 4, 0, 1};
        phase_outputs = '{2, 16, 0, 31, 5, 1, 0, 16};
        send_idle_pct = 35;
        recv_idle_pct = 69;
        hold_cycles   = 0;
        items_sent    = 0;
        loads_sent    = 0;
        rows_sent     = 0;
        clears_sent   = 0;
        unused_sent   = 0;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= gntt_pkg::MODE_LOAD;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_commands();

        for (int p = 0; p < 8; p++)
        begin
            settle();
            if (p == 6)
            begin
                phase_inputs[p]  = $urandom_range(0, 31);
                phase_outputs[p] = $urandom_range(0, 31);
            end
            write_register(gntt_pkg::REG_INPUT_COUNT, 5'(phase_inputs[p]));
            write_register(gntt_pkg::REG_OUTPUT_COUNT, 5'(phase_outputs[p]));
            if (p < 3)
            begin
                send_idle_pct = 35;
                recv_idle_pct = 69;
            end
            else if (p < 6)
            begin
                send_idle_pct = 69;
                recv_idle_pct = 35;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 5)
            begin
                hold_cycles = 3000;
            end
            if (p == 1 || p == 6)
            begin
                fill_netlist();
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                run_sequence();
            end
        end
        settle();

        $display("Sent %0d transactions: %0d gate loads, %0d row requests, %0d clears, %0d unused.",
                 items_sent, loads_sent, rows_sent, clears_sent, unused_sent);
        $display("Checked %0d rows over 8 count settings; %0d final rows, %0d with a full list.",
                 tt_checker.rows_checked, tt_checker.final_rows_seen, tt_checker.full_list_rows);
        if (tt_checker.error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("%0d mismatches found.", tt_checker.error_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/gntt_pkg.sv
rtl/gntt_ram.sv
rtl/gntt_apb_regs.sv
rtl/gntt_core.sv
rtl/gate_netlist_truth_table.sv
tb/tb_top.sv
